// ===== rtl/hotp_pkg.sv =====
// ----------------------------------------------------------------------------
// hotp_pkg - shared types and constants for the HOTP code checker
// SHA-1 constants, key masking, modulus and sequencer states.
// ----------------------------------------------------------------------------
package hotp_pkg;

	localparam int KEY_BYTES   = 20;
	localparam int CODE_DIGITS = 6;

	// 10^CODE_DIGITS
	function automatic int unsigned pow10(input int n);
		int unsigned r;
		r = 1;
		for (int i = 0; i < n; i++) r = r * 10;
		return r;
	endfunction

	localparam int unsigned MODULUS = pow10(CODE_DIGITS);

	// number of shift-subtract steps to reduce a 31-bit word by MODULUS
	function automatic int mod_steps(input longint unsigned m);
		int n;
		n = 0;
		for (int i = 0; i < 32; i++) begin
			if ((m << i) <= 64'h7fff_ffff) n = i + 1;
		end
		return n;
	endfunction

	localparam int MOD_STEPS = mod_steps(64'(MODULUS));

	// byte mask over the 64-byte key block, byte 0 in the top bits
	function automatic logic [511:0] key_mask();
		logic [511:0] m;
		m = '0;
		for (int i = 0; i < 64; i++) begin
			if (i < KEY_BYTES && i < 20) m[511 - 8*i -: 8] = 8'hff;
		end
		return m;
	endfunction

	localparam logic [159:0] SHA1_IV = {32'h67452301, 32'hEFCDAB89, 32'h98BADCFE,
		32'h10325476, 32'hC3D2E1F0};

	// message lengths in bits of the inner and outer hash
	localparam logic [63:0] INNER_LEN = 64'd576;
	localparam logic [63:0] OUTER_LEN = 64'd672;

	function automatic logic [31:0] sha1_k(input logic [6:0] rnd);
		if (rnd < 7'd20)      return 32'h5A827999;
		else if (rnd < 7'd40) return 32'h6ED9EBA1;
		else if (rnd < 7'd60) return 32'h8F1BBCDC;
		else                  return 32'hCA62C1D6;
	endfunction

	function automatic logic [31:0] sha1_f(input logic [6:0] rnd, input logic [31:0] b,
		input logic [31:0] c, input logic [31:0] d);
		if (rnd < 7'd20)      return (b & c) | (~b & d);
		else if (rnd < 7'd40) return b ^ c ^ d;
		else if (rnd < 7'd60) return (b & c) | (b & d) | (c & d);
		else                  return b ^ c ^ d;
	endfunction

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_ROUND,
		ST_ADD,
		ST_TRUNC,
		ST_MOD,
		ST_DONE
	} state_t;

endpackage

// ===== rtl/hotp_code_checker_core.sv =====
// ----------------------------------------------------------------------------
// hotp_code_checker_core - HMAC-SHA1 one-time-password check
// Hashes a moving factor with the configured key, truncates and reduces the
// digest to a decimal code, and compares it with a claimed code.
// ----------------------------------------------------------------------------
// Usage:
//   Write the key through cfg_we/cfg_index/cfg_data (index 0: key bytes 0-7,
//   1: bytes 8-15, 2: bytes 16-19, first byte most significant) while idle.
//   Send one transaction on s_* carrying the moving factor and the claimed
//   code; one result transaction follows on m_* with the computed code and a
//   match flag.
//   One shared SHA-1 round unit runs four 64-byte blocks (inner hash of two,
//   outer hash of two), each as a load, the rounds and an add, then a
//   truncation step and MOD_STEPS (12 for six digits) shift-subtract steps
//   for the modulo, and a hand-off in the done state. s_tready is high only
//   while the sequencer is idle.
//   The result sits in an output register; while a stalled receiver leaves it
//   there, the next result keeps the sequencer waiting in the done state until it is taken.
//   Reset clears the key to zero, the sequencer to idle and m_tvalid.
// ----------------------------------------------------------------------------
module hotp_code_checker_core (
	input  logic        clk,
	input  logic        arst_n,
	// configuration write port
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_data,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [87:0] s_tdata,   // [63:0] moving_factor, [83:64] candidate_code
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata    // [0] code_match, [20:1] computed_code
);

	localparam logic [1:0] REG_KEY0 = 2'd0;
	localparam logic [1:0] REG_KEY1 = 2'd1;
	localparam logic [1:0] REG_KEY2 = 2'd2;

	hotp_pkg::state_t state_q, state_d;

	logic [63:0]  key0_q, key1_q;
	logic [31:0]  key2_q;
	logic [63:0]  factor_q;
	logic [19:0]  cand_q;
	logic [1:0]   blk_q;
	logic [6:0]   round_q;
	logic [4:0]   step_q;
	logic [511:0] w_q;
	logic [31:0]  a_q, b_q, c_q, d_q, e_q;
	logic [159:0] h_q, inner_q;
	logic [31:0]  rem_q;
	logic         m_valid_q;
	logic         m_match_q;
	logic [19:0]  m_code_q;

	logic         in_acc, out_load;
	logic [511:0] key_blk, blk_data;
	logic [31:0]  w_new, t_sum;
	logic [159:0] h_new, h_shift;
	logic [31:0]  trunc_word, sub_val;

	// key registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key0_q <= '0;
			key1_q <= '0;
			key2_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_KEY0: key0_q <= cfg_data;
				REG_KEY1: key1_q <= cfg_data;
				REG_KEY2: key2_q <= cfg_data[31:0];
				default: ;
			endcase
		end
	end

	// block selection: padded key, factor block, padded key, digest block
	assign key_blk = {key0_q, key1_q, key2_q, 352'd0} & hotp_pkg::key_mask();
	always_comb begin
		case (blk_q)
			2'd0:    blk_data = key_blk ^ {64{8'h36}};
			2'd1:    blk_data = {factor_q, 8'h80, 376'd0, hotp_pkg::INNER_LEN};
			2'd2:    blk_data = key_blk ^ {64{8'h5c}};
			default: blk_data = {inner_q, 8'h80, 280'd0, hotp_pkg::OUTER_LEN};
		endcase
	end

	// round unit and schedule expansion
	assign w_new = {w_q[511-32*13 -: 32] ^ w_q[511-32*8 -: 32] ^ w_q[511-32*2 -: 32]
		^ w_q[511 -: 32]};
	assign t_sum = {a_q[26:0], a_q[31:27]} + hotp_pkg::sha1_f(round_q, b_q, c_q, d_q)
		+ e_q + hotp_pkg::sha1_k(round_q) + w_q[511 -: 32];
	assign h_new = {h_q[159:128] + a_q, h_q[127:96] + b_q, h_q[95:64] + c_q,
		h_q[63:32] + d_q, h_q[31:0] + e_q};

	// dynamic truncation and modulo step
	assign h_shift    = h_q << {h_q[3:0], 3'b000};
	assign trunc_word = {1'b0, h_shift[158:128]};
	assign sub_val    = 32'(hotp_pkg::MODULUS) << step_q;

	assign in_acc   = s_tvalid && s_tready;
	assign out_load = (state_q == hotp_pkg::ST_DONE) && (!m_valid_q || m_tready);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			hotp_pkg::ST_IDLE:  if (s_tvalid) state_d = hotp_pkg::ST_LOAD;
			hotp_pkg::ST_LOAD:  state_d = hotp_pkg::ST_ROUND;
			hotp_pkg::ST_ROUND: if (round_q == 7'd79) state_d = hotp_pkg::ST_ADD;
			hotp_pkg::ST_ADD:
				state_d = (blk_q == 2'd3) ? hotp_pkg::ST_TRUNC : hotp_pkg::ST_LOAD;
			hotp_pkg::ST_TRUNC: state_d = hotp_pkg::ST_MOD;
			hotp_pkg::ST_MOD:   if (step_q == 5'd0) state_d = hotp_pkg::ST_DONE;
			hotp_pkg::ST_DONE:  if (!m_valid_q || m_tready) state_d = hotp_pkg::ST_IDLE;
			default:            state_d = hotp_pkg::ST_IDLE;
		endcase
	end

	// handshake outputs
	always_comb begin
		s_tready = (state_q == hotp_pkg::ST_IDLE);
		m_tvalid = m_valid_q;
		m_tdata  = {3'd0, m_code_q, m_match_q};
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= hotp_pkg::ST_IDLE;
			blk_q     <= '0;
			round_q   <= '0;
			step_q    <= '0;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (in_acc) blk_q <= '0;
			else if (state_q == hotp_pkg::ST_ADD) blk_q <= blk_q + 2'd1;
			if (state_q == hotp_pkg::ST_LOAD) round_q <= '0;
			else if (state_q == hotp_pkg::ST_ROUND) round_q <= round_q + 7'd1;
			if (state_q == hotp_pkg::ST_TRUNC) step_q <= 5'(hotp_pkg::MOD_STEPS - 1);
			else if (state_q == hotp_pkg::ST_MOD && step_q != 5'd0)
				step_q <= step_q - 5'd1;
			if (out_load) m_valid_q <= 1'b1;
			else if (m_tready) m_valid_q <= 1'b0;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			factor_q <= s_tdata[63:0];
			cand_q   <= s_tdata[83:64];
		end
		case (state_q)
			hotp_pkg::ST_LOAD: begin
				w_q <= blk_data;
				if (!blk_q[0]) begin
					h_q <= hotp_pkg::SHA1_IV;
					{a_q, b_q, c_q, d_q, e_q} <= hotp_pkg::SHA1_IV;
				end else begin
					{a_q, b_q, c_q, d_q, e_q} <= h_q;
				end
			end
			hotp_pkg::ST_ROUND: begin
				w_q <= {w_q[479:0], w_new[30:0], w_new[31]};
				e_q <= d_q;
				d_q <= c_q;
				c_q <= {b_q[1:0], b_q[31:2]};
				b_q <= a_q;
				a_q <= t_sum;
			end
			hotp_pkg::ST_ADD: begin
				h_q <= h_new;
				if (blk_q == 2'd1) inner_q <= h_new;
			end
			hotp_pkg::ST_TRUNC: rem_q <= trunc_word;
			hotp_pkg::ST_MOD:   if (rem_q >= sub_val) rem_q <= rem_q - sub_val;
			default: ;
		endcase
		if (out_load) begin
			m_match_q <= (rem_q == {12'd0, cand_q});
			m_code_q  <= rem_q[19:0];
		end
	end

endmodule
